// ===== rtl/rom_ram_bank_mapper_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Clocked assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ROM_RAM_BANK_MAPPER_CORE_ASSERT_SVH
`define ROM_RAM_BANK_MAPPER_CORE_ASSERT_SVH

// Checked outside reset only.
`define RRBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define RRBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rrbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbm_pkg
// Types and codes shared by the cartridge bank mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rrbm_pkg;

  localparam logic [2:0] TGT_ROM_READ  = 3'd0;
  localparam logic [2:0] TGT_RAM_READ  = 3'd1;
  localparam logic [2:0] TGT_RAM_WRITE = 3'd2;
  localparam logic [2:0] TGT_OPEN_BUS  = 3'd3;
  localparam logic [2:0] TGT_NONE      = 3'd4;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Control register regions, selected by address bits 14:13 below 0x8000.
  localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
  localparam logic [1:0] REG_ROM_BANK   = 2'd1;
  localparam logic [1:0] REG_RAM_BANK   = 2'd2;
  localparam logic [1:0] REG_MODE       = 2'd3;

  localparam logic [2:0] RAM_WINDOW     = 3'b101;
  localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
  localparam logic [7:0] BANK_ALIAS     = 8'hE1;
  localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;

  typedef struct packed {
    logic        cmd;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [20:0] mem_address;
    logic [7:0]  mem_data;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/rom_ram_bank_mapper_core.sv =====
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_core
// Cartridge bank controller: maps each bus access to a ROM or RAM address.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata                                  tuser
// s_axis    in         [15:0] bus_address, [23:16] write_byte [0] cmd
// m_axis    out        [20:0] mem_address, [28:21] mem_data   [2:0] target
// cfg       in         cfg_wdata [3:0] rom_size_code          -
//
// One word is accepted per cycle unless a stalled result keeps in_valid set.
// The input register and the result register bound the single mapping stage.
// Reset clears both valid flags and returns the bank state to its defaults.
// A stalled result holds its register, and the input register fills behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module rom_ram_bank_mapper_core import rrbm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // [15:0] bus_address, [23:16] write_byte
  input  wire logic [0:0]  s_tuser,  // [0] cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // [20:0] mem_address, [28:21] mem_data
  output logic [2:0]       m_tuser   // [2:0] target
);

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t map_res;
  result_t out_res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= '{cmd: s_tuser[0], bus_address: s_tdata[15:0],
                   write_byte: s_tdata[23:16]};
    end
  end

  rrbm_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .fire      (advance),
    .item      (in_item),
    .res       (map_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= map_res;
    end
  end

  assign m_tdata = {3'b000, out_res.mem_data, out_res.mem_address};
  assign m_tuser = out_res.target;

endmodule

`default_nettype wire

// ===== rtl/rrbm_map.sv =====
// ----------------------------------------------------------------------------
// rrbm_map
// Bank state registers and the address mapping of one bus access.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbm_map import rrbm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wen,
  input  wire logic [3:0] cfg_wdata,
  input  wire logic       fire,
  input  wire item_t      item,
  output result_t         res
);

  logic [3:0] rom_size_code;
  logic       ram_enabled, ram_enabled_next;
  logic [6:0] rom_bank, rom_bank_next;
  logic [1:0] ram_bank, ram_bank_next;
  logic       advanced_mode, advanced_mode_next;

  logic [15:0] addr;
  logic [7:0]  wbyte;
  logic        is_wr;
  logic [4:0]  bank_mask;
  logic [6:0]  masked_bank;
  logic [6:0]  high_bank;
  logic [1:0]  mode_bank;

  always_comb begin
    case (rom_size_code)
      4'd0:    bank_mask = 5'h03;
      4'd1:    bank_mask = 5'h07;
      4'd2:    bank_mask = 5'h0F;
      default: bank_mask = 5'h1F;
    endcase
  end

  always_comb begin
    addr   = item.bus_address;
    wbyte  = item.write_byte;
    is_wr  = (item.cmd == CMD_WRITE);
    mode_bank   = advanced_mode ? ram_bank : 2'b00;
    high_bank   = (rom_bank == 7'd0) ? 7'd1 : rom_bank;
    masked_bank = {2'b00, wbyte[4:0] & bank_mask};
    if (rom_size_code > 4'd3) begin
      masked_bank = masked_bank | {ram_bank, 5'b00000};
    end

    ram_enabled_next   = ram_enabled;
    rom_bank_next      = rom_bank;
    ram_bank_next      = ram_bank;
    advanced_mode_next = advanced_mode;
    res = '{target: TGT_NONE, mem_address: 21'd0, mem_data: 8'd0};

    if (!addr[15]) begin
      if (is_wr) begin
        unique case (addr[14:13])
          REG_RAM_ENABLE: ram_enabled_next = (wbyte == RAM_ENABLE_KEY);
          REG_ROM_BANK: begin
            if (wbyte == 8'd0 || wbyte == BANK_ALIAS) begin
              rom_bank_next = 7'd1;
            end else if (wbyte[7:5] == 3'b000) begin
              rom_bank_next = wbyte[6:0];
            end else begin
              rom_bank_next = masked_bank;
            end
          end
          REG_RAM_BANK: ram_bank_next = wbyte[1:0];
          REG_MODE:     advanced_mode_next = wbyte[0];
          default:      ram_enabled_next = ram_enabled;
        endcase
      end else if (!addr[14]) begin
        res.target      = TGT_ROM_READ;
        res.mem_address = {mode_bank, 5'b00000, addr[13:0]};
      end else begin
        res.target      = TGT_ROM_READ;
        res.mem_address = {high_bank, addr[13:0]};
      end
    end else if (addr[15:13] == RAM_WINDOW) begin
      if (!ram_enabled) begin
        if (!is_wr) begin
          res.target   = TGT_OPEN_BUS;
          res.mem_data = OPEN_BUS_BYTE;
        end
      end else begin
        res.target      = is_wr ? TGT_RAM_WRITE : TGT_RAM_READ;
        res.mem_address = {6'b000000, mode_bank, addr[12:0]};
        res.mem_data    = is_wr ? wbyte : 8'd0;
      end
    end else if (!is_wr) begin
      res.target   = TGT_OPEN_BUS;
      res.mem_data = OPEN_BUS_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_code <= 4'd0;
      ram_enabled   <= 1'b0;
      rom_bank      <= 7'd1;
      ram_bank      <= 2'd0;
      advanced_mode <= 1'b0;
    end else begin
      if (cfg_wen) begin
        rom_size_code <= cfg_wdata;
      end
      if (fire) begin
        ram_enabled   <= ram_enabled_next;
        rom_bank      <= rom_bank_next;
        ram_bank      <= ram_bank_next;
        advanced_mode <= advanced_mode_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rrbm_checker.sv =====
// ----------------------------------------------------------------------------
// rrbm_checker
// Port-level assertions for the cartridge bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rom_ram_bank_mapper_core_assert.svh"

module rrbm_checker import rrbm_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  `RRBM_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

  `RRBM_ASSERT(a_open_bus, (m_tvalid && m_tuser == TGT_OPEN_BUS) |-> (m_tdata[28:21] == OPEN_BUS_BYTE && m_tdata[20:0] == 21'd0), "open bus word malformed")

  `RRBM_ASSERT(a_no_access, (m_tvalid && m_tuser == TGT_NONE) |-> (m_tdata == 32'd0), "no-access word not zero")

  `RRBM_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind rom_ram_bank_mapper_core rrbm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/rom_ram_bank_mapper_core_tb.sv =====
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_core_tb
// Drives cartridge bus accesses into the bank mapper and checks every mapped
// access against a cycle-free model of the bank state, over several ROM size
// codes, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rom_ram_bank_mapper_core_tb;
  import rrbm_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [3:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;  // [15:0] bus_address, [23:16] write_byte
  logic [0:0]  s_tuser;  // [0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;  // [20:0] mem_address, [28:21] mem_data
  logic [2:0]  m_tuser;  // [2:0] target

  rom_ram_bank_mapper_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Bank state as the mapper should hold it.
  logic       ram_on;
  logic [6:0] rom_bank_reg;
  logic [1:0] ram_bank_reg;
  logic       banking_mode;
  logic [3:0] rom_size;

  result_t awaited_mappings[$];
  int          error_count = 0;
  int          burst_left  = 0;
  bit          sender_gaps = 1'b1;
  int          rx_mode     = 0;
  int          rx_left     = 0;

  always #1 clk = ~clk;

  function automatic result_t predict_mapping(item_t acc);
    result_t     r;
    int unsigned addr;
    int unsigned phys;
    int unsigned bank;
    int unsigned bits;
    int unsigned masked;
    r.target      = TGT_NONE;
    r.mem_address = '0;
    r.mem_data    = '0;
    addr = acc.bus_address;
    if (addr < 'h8000) begin
      if (acc.cmd == CMD_WRITE) begin
        case (acc.bus_address[14:13])
          REG_RAM_ENABLE: ram_on = (acc.write_byte == RAM_ENABLE_KEY);
          REG_ROM_BANK: begin
            if (acc.write_byte == 8'h00 || acc.write_byte == BANK_ALIAS) begin
              rom_bank_reg = 7'd1;
            end else if (acc.write_byte < 8'h20) begin
              rom_bank_reg = acc.write_byte[6:0];
            end else begin
              bits = (rom_size < 4) ? rom_size + 2 : 5;
              masked = acc.write_byte & ((1 << bits) - 1);
              if (rom_size > 3) masked = masked | (ram_bank_reg << 5);
              rom_bank_reg = masked[6:0];
            end
          end
          REG_RAM_BANK: ram_bank_reg = acc.write_byte[1:0];
          default: banking_mode = acc.write_byte[0];
        endcase
      end else if (addr < 'h4000) begin
        phys = addr + (banking_mode ? (ram_bank_reg << 19) : 0);
        r.target      = TGT_ROM_READ;
        r.mem_address = phys[20:0];
      end else begin
        bank = (rom_bank_reg == 0) ? 1 : rom_bank_reg;
        phys = (addr - 'h4000) + bank * 'h4000;
        r.target      = TGT_ROM_READ;
        r.mem_address = phys[20:0];
      end
    end else if (addr >= 'hA000 && addr <= 'hBFFF) begin
      bank = banking_mode ? ram_bank_reg : 0;
      phys = (addr - 'hA000) + bank * 'h2000;
      if (!ram_on) begin
        if (acc.cmd == CMD_READ) begin
          r.target   = TGT_OPEN_BUS;
          r.mem_data = OPEN_BUS_BYTE;
        end
      end else if (acc.cmd == CMD_WRITE) begin
        r.target      = TGT_RAM_WRITE;
        r.mem_address = phys[20:0];
        r.mem_data    = acc.write_byte;
      end else begin
        r.target      = TGT_RAM_READ;
        r.mem_address = phys[20:0];
      end
    end else if (acc.cmd == CMD_READ) begin
      r.target   = TGT_OPEN_BUS;
      r.mem_data = OPEN_BUS_BYTE;
    end
    return r;
  endfunction

  function automatic item_t random_access();
    item_t       acc;
    int unsigned pick;
    acc.cmd         = 1'($urandom_range(0, 1));
    acc.bus_address = 16'($urandom_range(0, 'hFFFF));
    acc.write_byte  = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      acc.cmd         = CMD_WRITE;
      acc.bus_address = 16'($urandom_range(0, 'h1FFF));
      if ($urandom_range(0, 2) != 0) acc.write_byte = RAM_ENABLE_KEY;
    end else if (pick < 20) begin
      acc.cmd         = CMD_WRITE;
      acc.bus_address = 16'($urandom_range('h2000, 'h3FFF));
      case ($urandom_range(0, 3))
        0: acc.write_byte = 8'h00;
        1: acc.write_byte = BANK_ALIAS;
        2: acc.write_byte = 8'($urandom_range(0, 'h1F));
        default: ;
      endcase
    end else if (pick < 26) begin
      acc.cmd         = CMD_WRITE;
      acc.bus_address = 16'($urandom_range('h4000, 'h7FFF));
    end else if (pick < 56) begin
      acc.cmd         = CMD_READ;
      acc.bus_address = 16'($urandom_range(0, 'h7FFF));
    end else if (pick < 86) begin
      acc.bus_address = 16'($urandom_range('hA000, 'hBFFF));
    end
    return acc;
  endfunction

  task automatic send_word(item_t acc);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {acc.write_byte, acc.bus_address};
    s_tuser  <= acc.cmd;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    awaited_mappings.push_back(predict_mapping(acc));
  endtask

  task automatic stop_sending();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (awaited_mappings.size() != 0) @(posedge clk);
  endtask

  task automatic set_rom_size(logic [3:0] code);
    stop_sending();
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    rom_size = code;
    cfg_wen  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_word(item_t'{CMD_READ,  16'h0000, 8'h00});
    send_word(item_t'{CMD_READ,  16'h7FFF, 8'hFF});
    send_word(item_t'{CMD_READ,  16'hA000, 8'h00});
    send_word(item_t'{CMD_WRITE, 16'hBFFF, 8'hFF});
    send_word(item_t'{CMD_READ,  16'h8000, 8'h00});
    send_word(item_t'{CMD_WRITE, 16'hFFFF, 8'hFF});
  endtask

  task automatic test_control_writes();
    send_word(item_t'{CMD_WRITE, 16'h1FFF, RAM_ENABLE_KEY});
    send_word(item_t'{CMD_WRITE, 16'hA000, 8'hFF});
    send_word(item_t'{CMD_READ,  16'hBFFF, 8'h00});
    send_word(item_t'{CMD_WRITE, 16'h2000, 8'h00});
    send_word(item_t'{CMD_WRITE, 16'h3FFF, BANK_ALIAS});
    send_word(item_t'{CMD_WRITE, 16'h2000, 8'h1F});
    send_word(item_t'{CMD_READ,  16'h4000, 8'h00});
    // A masked bank of zero must still read as bank one.
    send_word(item_t'{CMD_WRITE, 16'h2000, 8'h20});
    send_word(item_t'{CMD_READ,  16'h7FFF, 8'h00});
    send_word(item_t'{CMD_WRITE, 16'h5FFF, 8'hFF});
    send_word(item_t'{CMD_WRITE, 16'h6000, 8'h01});
    send_word(item_t'{CMD_READ,  16'h3FFF, 8'h00});
    send_word(item_t'{CMD_READ,  16'hA000, 8'h00});
    send_word(item_t'{CMD_WRITE, 16'h7FFF, 8'hFE});
    send_word(item_t'{CMD_WRITE, 16'h0000, 8'h0B});
    send_word(item_t'{CMD_READ,  16'hA000, 8'h00});
  endtask

  task automatic test_rom_size_extremes();
    logic [3:0] codes[3];
    codes = '{4'd4, 4'd15, 4'd0};
    foreach (codes[i]) begin
      set_rom_size(codes[i]);
      send_word(item_t'{CMD_WRITE, 16'h2000, 8'hFF});
      send_word(item_t'{CMD_READ,  16'h4000, 8'h00});
    end
  endtask

  task automatic test_random_traffic();
    logic [3:0] codes[8];
    codes = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd8, 4'd15, 4'd0};
    codes[7] = 4'($urandom_range(0, 15));
    foreach (codes[i]) begin
      set_rom_size(codes[i]);
      sender_gaps = (i % 3 != 1);
      for (int n = 0; n < 250; n++) begin
        if (i == 2 && n == 120) begin
          // Hold off until the mapper has returned everything in flight.
          stop_sending();
          wait_drained();
        end
        send_word(random_access());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((rx_left % 8) < 5);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_mappings.size() == 0) begin
        $error("result word with none expected: target %0d", m_tuser);
        error_count++;
      end else begin
        want = awaited_mappings.pop_front();
        if (m_tuser !== want.target) begin
          $error("target: expected %0d, actual %0d", want.target, m_tuser);
          error_count++;
        end
        if (m_tdata[20:0] !== want.mem_address) begin
          $error("mem_address: expected %h, actual %h", want.mem_address, m_tdata[20:0]);
          error_count++;
        end
        if (m_tdata[28:21] !== want.mem_data) begin
          $error("mem_data: expected %h, actual %h", want.mem_data, m_tdata[28:21]);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_wen      = 1'b0;
    cfg_wdata    = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    m_tready     = 1'b0;
    ram_on       = 1'b0;
    rom_bank_reg = 7'd1;
    ram_bank_reg = 2'd0;
    banking_mode = 1'b0;
    rom_size     = 4'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_control_writes();
    test_rom_size_extremes();
    test_random_traffic();

    stop_sending();
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0 && awaited_mappings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
